@@ hw/rtl/sida_pkg.sv @@
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII package
// Shared character codes and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sida_pkg;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam int unsigned DIGIT_BITS = 4;

  typedef struct packed {
    logic load;
    logic convert;
    logic skip;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic top_zero;
    logic negative;
  } sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/signed_int_to_decimal_ascii_top.sv @@
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII converter, top level
// Converts one two's complement value into its decimal text, one character
// per strobe, most significant first, with the last character flagged.
//
//   Channel  Ports                                      Transfer
//   input    start, busy, in_value                      start && !busy
//   result   out_valid, out_text_char, out_last_char    out_valid
//
// A transaction keeps busy high through conversion, zero removal, the sign
// when the value is negative, and every digit (NDIG = 10 digits at 32 bits).
// The magnitude is converted to BCD one bit per cycle, then leading zero
// digits are dropped one per cycle, then one character leaves per cycle.
// Reset is synchronous and active low; it returns the block to idle.
// Results cannot be stalled; each is presented for exactly one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_decimal_ascii_top #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  output logic [7:0]            out_text_char,
  output logic                  out_last_char
);
  import sida_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sida_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  sida_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_text_char (out_text_char),
    .out_last_char (out_last_char)
  );

endmodule

`default_nettype wire

@@ hw/rtl/sida_datapath.sv @@
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII datapath
// Forms the magnitude, converts it to BCD one bit per cycle by shift and
// add-three, drops leading zero digits and emits characters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sida_datapath #(
  parameter int VALUE_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [VALUE_BITS-1:0]   in_value,
  input  sida_pkg::cmd_t          cmd,
  output sida_pkg::sts_t          sts,
  output logic                    out_valid,
  output logic [7:0]              out_text_char,
  output logic                    out_last_char
);
  import sida_pkg::*;

  localparam int NDIG = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int BW   = NDIG * DIGIT_BITS;
  localparam int CW   = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] bin_r, bin_nxt;
  logic [BW-1:0]         bcd_r, bcd_nxt, bcd_adj;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  neg_r, neg_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [DIGIT_BITS-1:0] top_digit;

  assign top_digit = bcd_r[BW-1 -: DIGIT_BITS];

  assign sts.cnt_zero = (cnt_r == '0);
  assign sts.top_zero = (top_digit == '0);
  assign sts.negative = neg_r;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[i*DIGIT_BITS +: DIGIT_BITS] >= 4'd5) begin
        bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_r[i*DIGIT_BITS +: DIGIT_BITS] + 4'd3;
      end else begin
        bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_r[i*DIGIT_BITS +: DIGIT_BITS];
      end
    end
  end

  always_comb begin
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (cmd.load) begin
      neg_nxt = in_value[VALUE_BITS-1];
      bin_nxt = in_value[VALUE_BITS-1] ? (~in_value + VALUE_BITS'(1)) : in_value;
      bcd_nxt = '0;
      cnt_nxt = CW'(VALUE_BITS - 1);
    end else if (cmd.convert) begin
      {bcd_nxt, bin_nxt} = {bcd_adj[BW-2:0], bin_r, 1'b0};
      cnt_nxt = sts.cnt_zero ? CW'(NDIG - 1) : cnt_r - CW'(1);
    end else if (cmd.skip) begin
      bcd_nxt = {bcd_r[BW-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
      cnt_nxt = cnt_r - CW'(1);
    end else if (cmd.emit_sign) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = CHAR_MINUS;
      out_last_nxt  = 1'b0;
    end else if (cmd.emit_digit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = CHAR_ZERO + {4'b0000, top_digit};
      out_last_nxt  = sts.cnt_zero;
      bcd_nxt       = {bcd_r[BW-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
      cnt_nxt       = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    cnt_r      <= cnt_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_text_char = out_char_r;
  assign out_last_char = out_last_r;

  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_char_r == CHAR_MINUS) ||
                    ((out_char_r >= CHAR_ZERO) && (out_char_r <= CHAR_ZERO + 8'd9)))
    else $error("Emitted character is neither a digit nor a minus sign.");

  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_char_r == CHAR_MINUS)) |-> !out_last_r)
    else $error("Minus sign flagged as the last character.");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |=> !out_valid_r)
    else $error("Character emitted right after the last character of a transaction.");

  a_sign_only_negative: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_sign |-> neg_r)
    else $error("Minus sign requested for a non-negative value.");

endmodule

`default_nettype wire

@@ hw/rtl/sida_ctrl.sv @@
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII controller
// Sequences loading, conversion, leading zero removal and emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sida_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  sida_pkg::sts_t sts,
  output sida_pkg::cmd_t cmd
);
  import sida_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CONV  = 5'b00010,
    S_SKIP  = 5'b00100,
    S_SIGN  = 5'b01000,
    S_DIGIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        cmd.convert = 1'b1;
        if (sts.cnt_zero) begin
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        if (sts.top_zero && !sts.cnt_zero) begin
          cmd.skip = 1'b1;
        end else begin
          state_nxt = sts.negative ? S_SIGN : S_DIGIT;
        end
      end
      S_SIGN: begin
        cmd.emit_sign = 1'b1;
        state_nxt     = S_DIGIT;
      end
      S_DIGIT: begin
        cmd.emit_digit = 1'b1;
        if (sts.cnt_zero) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  a_start_takes: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("Accepted transaction did not make the block busy.");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.convert, cmd.skip, cmd.emit_sign, cmd.emit_digit}))
    else $error("More than one datapath command in a cycle.");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !busy)
    else $error("Load issued while busy.");

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII converter testbench
// Drives signed 32-bit values into the converter and checks every character
// strobe against the expected decimal text. The run covers the sign, digit
// counts from one to ten, zero and the most negative value, then random values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  import sida_pkg::*;

  localparam int VALUE_BITS = 32;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
  } text_char_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [VALUE_BITS-1:0] in_value;
  logic                  out_valid;
  logic [7:0]            out_text_char;
  logic                  out_last_char;

  logic [VALUE_BITS-1:0] pending_values[$];
  text_char_t            expected_text[$];
  logic                  handed_off;
  int                    gap_left;
  int                    error_count = 0;
  bit                    idling_on;

  signed_int_to_decimal_ascii_top #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_text_char(out_text_char),
    .out_last_char(out_last_char)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void append_decimal_text(input logic [VALUE_BITS-1:0] value);
    logic [VALUE_BITS-1:0] magnitude;
    logic [7:0]            digits[$];
    logic                  negative;
    text_char_t            entry;
    negative  = value[VALUE_BITS-1];
    magnitude = negative ? (~value + VALUE_BITS'(1)) : value;
    do begin
      digits.push_front(CHAR_ZERO + 8'(magnitude % 10));
      magnitude = magnitude / 10;
    end while (magnitude != 0);
    if (negative) begin
      entry.text_char = CHAR_MINUS;
      entry.last_char = 1'b0;
      expected_text.push_back(entry);
    end
    foreach (digits[i]) begin
      entry.text_char = digits[i];
      entry.last_char = (i == digits.size() - 1);
      expected_text.push_back(entry);
    end
  endfunction

  function automatic logic [VALUE_BITS-1:0] random_value_of_length(input int num_digits);
    longint lo;
    longint hi;
    longint magnitude;
    lo = 1;
    for (int i = 1; i < num_digits; i++) lo = lo * 10;
    hi = lo * 10 - 1;
    if (num_digits == 1) lo = 0;
    if (hi > 64'd2147483648) hi = 64'd2147483648;
    magnitude = lo + longint'($urandom_range(32'(hi - lo), 0));
    if (magnitude == 64'd2147483648 || $urandom_range(0, 1) == 1) begin
      return VALUE_BITS'(-magnitude);
    end
    return VALUE_BITS'(magnitude);
  endfunction

  // Driver: a new transaction is offered once the previous one has been taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      in_value <= '0;
      gap_left <= 0;
    end else if (!start || handed_off) begin
      if (gap_left > 0) begin
        if (!busy) gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_values.size() > 0) begin
        in_value <= pending_values.pop_front();
        start    <= 1'b1;
        if (idling_on && pending_values.size() > 30 && $urandom_range(0, 2) == 0) begin
          gap_left <= $urandom_range(1, 11);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: record accepted transactions and check every character strobe.
  always @(posedge clk) begin
    text_char_t wanted;
    handed_off <= rst_n && start && !busy;
    if (rst_n && start && !busy) append_decimal_text(in_value);
    if (rst_n && out_valid) begin
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected character %0d last %0b", $time, out_text_char,
                 out_last_char);
        error_count++;
      end else begin
        wanted = expected_text.pop_front();
        if (out_text_char !== wanted.text_char) begin
          $display("%0t: text_char expected %0d actual %0d", $time, wanted.text_char,
                   out_text_char);
          error_count++;
        end
        if (out_last_char !== wanted.last_char) begin
          $display("%0t: last_char expected %0b actual %0b", $time, wanted.last_char,
                   out_last_char);
          error_count++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    longint directed[$];
    int     pick;
    rst_n       = 1'b0;
    idling_on   = 1'b1;

    directed = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 7, 1000000000, 999999999,
                 -999999999, 1234567890, -1234567890, 2147483647, -2147483647,
                 -64'sd2147483648, 2147483646, -1000000000, 4294967, 65536, -32768};
    foreach (directed[i]) pending_values.push_back(VALUE_BITS'(directed[i]));
    for (int i = 0; i < 226; i++) begin
      pick = $urandom_range(0, 3);
      if (pick == 0) begin
        pending_values.push_back(VALUE_BITS'($urandom()));
      end else begin
        pending_values.push_back(random_value_of_length($urandom_range(1, 10)));
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_values.size() > 40) @(posedge clk);
    idling_on = 1'b0;
    while (pending_values.size() > 0 || start || busy || expected_text.size() > 0) begin
      @(posedge clk);
    end
    repeat (50) @(posedge clk);

    if (expected_text.size() != 0) begin
      $display("%0t: %0d expected characters never arrived", $time, expected_text.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
